>>> rtl/mrlb_pkg.sv
// ----------------------------------------------------------------------------
// mrlb_pkg: shared definitions for the line break cost engine
// Widths, window and word limits, state codes and the structs passed
// between the sequencer and the candidate cost unit.
// ----------------------------------------------------------------------------
package mrlb_pkg;

   localparam int MAX_WORDS    = 2048;
   localparam int WINDOW_DEPTH = 256;

   localparam int SLOT_W   = $clog2(WINDOW_DEPTH);
   localparam int CNT_W    = $clog2(MAX_WORDS + 1);
   localparam int SPAN_MAX = WINDOW_DEPTH - 1;

   localparam int LEN_W    = 8;
   localparam int LW_W     = 8;
   localparam int IDX_W    = 12;
   localparam int PREFIX_W = 20;
   localparam int COST_W   = 40;
   localparam int SQ_W     = 2 * LW_W;
   localparam int CUBE_W   = 3 * LW_W;
   localparam int SLACK_W  = PREFIX_W + 2;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [COST_W-1:0] COST_MAX = '1;
   localparam logic [LW_W-1:0]   LINE_WIDTH_RESET = 8'd80;

   // register index decoded from paddr[2]
   localparam logic REG_LINE_WIDTH = 1'b0;

   typedef logic [CNT_W-1:0]    cnt_type;
   typedef logic [SLOT_W-1:0]   slot_type;
   typedef logic [PREFIX_W-1:0] prefix_type;
   typedef logic [COST_W-1:0]   cost_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREFIX,
      ST_SCAN,
      ST_DRAIN,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic    valid;
      cnt_type index;
   } issue_type;

   typedef struct packed {
      logic     feasible;
      cost_type cost;
   } cost_entry_type;

   typedef struct packed {
      logic     found;
      cost_type cost;
      cnt_type  start;
   } best_type;

endpackage

>>> rtl/min_raggedness_line_break.sv
// ----------------------------------------------------------------------------
// min_raggedness_line_break: minimum raggedness line break cost engine
// Takes one word length per word and returns the best paragraph cost so far
// and the start of the last line, with cubic slack penalty (none on the last line).
// ----------------------------------------------------------------------------
// Each accepted word runs PREFIX, SCAN over n = min(word index, span) starts,
// span = (line_width+1)/2 (no SCAN at line_width 0), DRAIN until the cost
// pipeline empties, and WRITE, held while a result waits. A new word is taken
// only when idle. SCAN issues one start per cycle into the cost pipeline,
// limited by the single ring read port. Over-limit words go straight to WRITE.
// Reset (synchronous, active high): line_width = 80, word count 0, idle.
module min_raggedness_line_break (
   input  logic                              clock,
   input  logic                              reset,
   // request
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [mrlb_pkg::LEN_W-1:0]        req_word_length,
   input  logic                              req_last_word,
   // response
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [mrlb_pkg::IDX_W-1:0]        rsp_word_index,
   output logic [mrlb_pkg::COST_W-1:0]       rsp_best_cost,
   output logic [mrlb_pkg::IDX_W-1:0]        rsp_line_start,
   output logic                              rsp_no_fit,
   output logic                              rsp_is_last,
   // csr
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [mrlb_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [mrlb_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [mrlb_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   mrlb_pkg::state_type          state_ff, state_in;
   logic [mrlb_pkg::LW_W-1:0]    line_width_ff, line_width_in;
   mrlb_pkg::cnt_type            word_count_ff, word_count_in;
   logic [mrlb_pkg::LEN_W-1:0]   len_ff, len_in;
   logic                         last_ff, last_in;
   logic                         ovf_ff, ovf_in;
   mrlb_pkg::cnt_type            j_ff, j_in;
   mrlb_pkg::prefix_type         pj_ff, pj_in;
   mrlb_pkg::cnt_type            i_ff, i_in;
   mrlb_pkg::issue_type          issue_ff, issue_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [mrlb_pkg::IDX_W-1:0]   rsp_index_ff, rsp_index_in;
   mrlb_pkg::cost_type           rsp_cost_ff, rsp_cost_in;
   logic [mrlb_pkg::IDX_W-1:0]   rsp_start_ff, rsp_start_in;
   logic                         rsp_no_fit_ff, rsp_no_fit_in;
   logic                         rsp_last_ff, rsp_last_in;

   mrlb_pkg::slot_type           ring_raddr;
   logic                         prefix_we;
   mrlb_pkg::prefix_type         prefix_rd;
   logic                         cost_we;
   mrlb_pkg::cost_entry_type     cost_wdata;
   mrlb_pkg::cost_entry_type     cost_rd;

   logic                         unit_clear;
   logic                         unit_busy;
   mrlb_pkg::best_type           best;

   logic [mrlb_pkg::LW_W:0]      half_w;
   mrlb_pkg::cnt_type            span;
   mrlb_pkg::cnt_type            first;
   logic                         found;
   logic                         csr_write;

   assign csr_write = csr_psel & csr_penable & csr_pwrite
                    & (csr_paddr[2] == mrlb_pkg::REG_LINE_WIDTH);

   always_comb begin
      line_width_in = line_width_ff;
      if (csr_write) begin
         line_width_in = csr_pwdata[mrlb_pkg::LW_W-1:0];
      end
      csr_prdata = '0;
      if (csr_paddr[2] == mrlb_pkg::REG_LINE_WIDTH) begin
         csr_prdata = mrlb_pkg::CSR_DATA_W'(line_width_ff);
      end
   end

   assign csr_pready = 1'b1;

   mrlb_ram #(
      .WIDTH (mrlb_pkg::PREFIX_W),
      .DEPTH (mrlb_pkg::WINDOW_DEPTH)
   ) u_prefix_ring (
      .clock (clock),
      .we    (prefix_we),
      .waddr (j_ff[mrlb_pkg::SLOT_W-1:0]),
      .wdata (pj_in),
      .raddr (ring_raddr),
      .rdata (prefix_rd)
   );

   mrlb_ram #(
      .WIDTH ($bits(mrlb_pkg::cost_entry_type)),
      .DEPTH (mrlb_pkg::WINDOW_DEPTH)
   ) u_cost_ring (
      .clock (clock),
      .we    (cost_we),
      .waddr (j_ff[mrlb_pkg::SLOT_W-1:0]),
      .wdata (cost_wdata),
      .raddr (ring_raddr),
      .rdata (cost_rd)
   );

   mrlb_cost_unit u_cost_unit (
      .clock      (clock),
      .reset      (reset),
      .clear      (unit_clear),
      .issue      (issue_ff),
      .line_width (line_width_ff),
      .word_j     (j_ff),
      .prefix_j   (pj_ff),
      .last       (last_ff),
      .prefix_rd  (prefix_rd),
      .cost_rd    (cost_rd),
      .busy       (unit_busy),
      .best       (best)
   );

   // candidate window
   always_comb begin
      half_w = ((mrlb_pkg::LW_W + 1)'(line_width_ff) + 1'b1) >> 1;
      span   = mrlb_pkg::CNT_W'(half_w);
      if (span > mrlb_pkg::CNT_W'(mrlb_pkg::SPAN_MAX)) begin
         span = mrlb_pkg::CNT_W'(mrlb_pkg::SPAN_MAX);
      end
      first = (j_ff > span) ? j_ff - span + 1'b1 : mrlb_pkg::CNT_W'(1);
   end

   assign found = best.found & ~ovf_ff;

   always_comb begin
      state_in      = state_ff;
      word_count_in = word_count_ff;
      len_in        = len_ff;
      last_in       = last_ff;
      ovf_in        = ovf_ff;
      j_in          = j_ff;
      pj_in         = pj_ff;
      i_in          = i_ff;
      issue_in      = '0;
      req_ready     = 1'b0;
      unit_clear    = 1'b0;
      prefix_we     = 1'b0;
      cost_we       = 1'b0;
      ring_raddr    = word_count_ff[mrlb_pkg::SLOT_W-1:0];
      cost_wdata.feasible = found;
      cost_wdata.cost     = found ? best.cost : mrlb_pkg::COST_MAX;

      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_index_in  = rsp_index_ff;
      rsp_cost_in   = rsp_cost_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_no_fit_in = rsp_no_fit_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         mrlb_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               len_in   = req_word_length;
               last_in  = req_last_word;
               ovf_in   = word_count_ff >= mrlb_pkg::CNT_W'(mrlb_pkg::MAX_WORDS);
               j_in     = word_count_ff + 1'b1;
               state_in = ovf_in ? mrlb_pkg::ST_WRITE : mrlb_pkg::ST_PREFIX;
            end
         end
         mrlb_pkg::ST_PREFIX: begin
            unit_clear = 1'b1;
            prefix_we  = 1'b1;
            pj_in      = ((j_ff == mrlb_pkg::CNT_W'(1)) ? '0 : prefix_rd)
                       + mrlb_pkg::PREFIX_W'(len_ff);
            i_in       = first;
            state_in   = (span == '0) ? mrlb_pkg::ST_DRAIN : mrlb_pkg::ST_SCAN;
         end
         mrlb_pkg::ST_SCAN: begin
            ring_raddr     = mrlb_pkg::SLOT_W'(i_ff - 1'b1);
            issue_in.valid = 1'b1;
            issue_in.index = i_ff;
            i_in           = i_ff + 1'b1;
            if (i_ff == j_ff) begin
               state_in = mrlb_pkg::ST_DRAIN;
            end
         end
         mrlb_pkg::ST_DRAIN: begin
            if (!unit_busy) begin
               state_in = mrlb_pkg::ST_WRITE;
            end
         end
         mrlb_pkg::ST_WRITE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cost_we       = ~ovf_ff;
               rsp_valid_in  = 1'b1;
               rsp_index_in  = ovf_ff ? mrlb_pkg::IDX_W'(mrlb_pkg::MAX_WORDS)
                                      : mrlb_pkg::IDX_W'(j_ff);
               rsp_cost_in   = cost_wdata.cost;
               rsp_start_in  = found ? mrlb_pkg::IDX_W'(best.start) : '0;
               rsp_no_fit_in = ~found;
               rsp_last_in   = last_ff;
               if (last_ff) begin
                  word_count_in = '0;
               end else if (!ovf_ff) begin
                  word_count_in = j_ff;
               end
               state_in = mrlb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mrlb_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mrlb_pkg::ST_IDLE;
         line_width_ff <= mrlb_pkg::LINE_WIDTH_RESET;
         word_count_ff <= '0;
         issue_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         line_width_ff <= line_width_in;
         word_count_ff <= word_count_in;
         issue_ff      <= issue_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff        <= len_in;
      last_ff       <= last_in;
      ovf_ff        <= ovf_in;
      j_ff          <= j_in;
      pj_ff         <= pj_in;
      i_ff          <= i_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_cost_ff   <= rsp_cost_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_no_fit_ff <= rsp_no_fit_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_word_index = rsp_index_ff;
   assign rsp_best_cost  = rsp_cost_ff;
   assign rsp_line_start = rsp_start_ff;
   assign rsp_no_fit     = rsp_no_fit_ff;
   assign rsp_is_last    = rsp_last_ff;

endmodule

>>> rtl/mrlb_ram.sv
// ----------------------------------------------------------------------------
// mrlb_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mrlb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/mrlb_cost_unit.sv
// ----------------------------------------------------------------------------
// mrlb_cost_unit: candidate line cost pipeline
// Per candidate start: slack from prefix sums, square, cube, add to the
// base cost with saturation, and keep the cheapest (earliest on a tie).
// ----------------------------------------------------------------------------
module mrlb_cost_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        clear,
   input  mrlb_pkg::issue_type         issue,
   input  logic [mrlb_pkg::LW_W-1:0]   line_width,
   input  mrlb_pkg::cnt_type           word_j,
   input  mrlb_pkg::prefix_type        prefix_j,
   input  logic                        last,
   input  mrlb_pkg::prefix_type        prefix_rd,
   input  mrlb_pkg::cost_entry_type    cost_rd,
   output logic                        busy,
   output mrlb_pkg::best_type          best
);

   // stage 1: slack
   logic                          s1_v_ff, s1_v_in;
   logic                          s1_ok_ff, s1_ok_in;
   logic [mrlb_pkg::LW_W-1:0]     s1_s_ff, s1_s_in;
   mrlb_pkg::cost_type            s1_base_ff, s1_base_in;
   mrlb_pkg::cnt_type             s1_i_ff, s1_i_in;
   // stage 2: square
   logic                          s2_v_ff, s2_ok_ff;
   logic [mrlb_pkg::LW_W-1:0]     s2_s_ff;
   logic [mrlb_pkg::SQ_W-1:0]     s2_sq_ff, s2_sq_in;
   mrlb_pkg::cost_type            s2_base_ff;
   mrlb_pkg::cnt_type             s2_i_ff;
   // stage 3: cube
   logic                          s3_v_ff, s3_ok_ff;
   logic [mrlb_pkg::CUBE_W-1:0]   s3_cube_ff, s3_cube_in;
   mrlb_pkg::cost_type            s3_base_ff;
   mrlb_pkg::cnt_type             s3_i_ff;

   mrlb_pkg::best_type            best_ff, best_in;

   mrlb_pkg::prefix_type          base_prefix;
   logic                          base_feasible;
   mrlb_pkg::cost_type            base_cost;
   mrlb_pkg::prefix_type          seg_sum;
   logic [mrlb_pkg::SLACK_W-1:0]  slack;
   logic [mrlb_pkg::CUBE_W-1:0]   line_cost;
   logic [mrlb_pkg::COST_W:0]     cand_sum;
   mrlb_pkg::cost_type            cand;

   // stage 1: start word one begins right after word zero (cost 0, feasible)
   always_comb begin
      if (issue.index == mrlb_pkg::CNT_W'(1)) begin
         base_prefix   = '0;
         base_feasible = 1'b1;
         base_cost     = '0;
      end else begin
         base_prefix   = prefix_rd;
         base_feasible = cost_rd.feasible;
         base_cost     = cost_rd.cost;
      end
      seg_sum    = prefix_j - base_prefix;
      slack      = mrlb_pkg::SLACK_W'(line_width)
                 - mrlb_pkg::SLACK_W'(word_j - issue.index)
                 - mrlb_pkg::SLACK_W'(seg_sum);
      s1_v_in    = issue.valid;
      s1_ok_in   = base_feasible & ~slack[mrlb_pkg::SLACK_W-1];
      s1_s_in    = slack[mrlb_pkg::LW_W-1:0];
      s1_base_in = base_cost;
      s1_i_in    = issue.index;
   end

   assign s2_sq_in   = mrlb_pkg::SQ_W'(s1_s_ff) * mrlb_pkg::SQ_W'(s1_s_ff);
   assign s3_cube_in = mrlb_pkg::CUBE_W'(s2_sq_ff) * mrlb_pkg::CUBE_W'(s2_s_ff);

   // stage 4: accumulate and select
   always_comb begin
      line_cost = last ? '0 : s3_cube_ff;
      cand_sum  = {1'b0, s3_base_ff} + (mrlb_pkg::COST_W + 1)'(line_cost);
      cand      = cand_sum[mrlb_pkg::COST_W] ? mrlb_pkg::COST_MAX
                                              : cand_sum[mrlb_pkg::COST_W-1:0];
      best_in   = best_ff;
      if (clear) begin
         best_in = '0;
      end else if (s3_v_ff && s3_ok_ff && (!best_ff.found || cand < best_ff.cost)) begin
         best_in.found = 1'b1;
         best_in.cost  = cand;
         best_in.start = s3_i_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         best_ff <= '0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         best_ff <= best_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ok_ff   <= s1_ok_in;
      s1_s_ff    <= s1_s_in;
      s1_base_ff <= s1_base_in;
      s1_i_ff    <= s1_i_in;
      s2_ok_ff   <= s1_ok_ff;
      s2_s_ff    <= s1_s_ff;
      s2_sq_ff   <= s2_sq_in;
      s2_base_ff <= s1_base_ff;
      s2_i_ff    <= s1_i_ff;
      s3_ok_ff   <= s2_ok_ff;
      s3_cube_ff <= s3_cube_in;
      s3_base_ff <= s2_base_ff;
      s3_i_ff    <= s2_i_ff;
   end

   assign busy = issue.valid | s1_v_ff | s2_v_ff | s3_v_ff;
   assign best = best_ff;

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: regression bench for the min raggedness line break engine
// Feeds word lengths over the request channel and checks every result word
// against a table entry or a local cubic-penalty predictor. Runs a table of
// directed words, then random paragraphs at line widths such as zero, one,
// full and random, a long response hold-off and random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
   import mrlb_pkg::*;

   localparam int CLOCK_LIMIT   = 3_000_000;
   localparam int SETTLE_CYCLES = 160;
   localparam int HOLD_CYCLES   = 2000;
   localparam int PRINT_LIMIT   = 50;

   typedef struct packed {
      logic [IDX_W-1:0]  index;
      logic [COST_W-1:0] cost;
      logic [IDX_W-1:0]  start;
      logic              no_fit;
      logic              is_last;
   } break_type;

   typedef struct packed {
      logic [LEN_W-1:0] len;
      logic             last;
      logic             known;
      break_type        typed;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid       = 1'b0;
   logic                  req_ready;
   logic [LEN_W-1:0]      req_word_length = '0;
   logic                  req_last_word   = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready       = 1'b0;
   logic [IDX_W-1:0]      rsp_word_index;
   logic [COST_W-1:0]     rsp_best_cost;
   logic [IDX_W-1:0]      rsp_line_start;
   logic                  rsp_no_fit;
   logic                  rsp_is_last;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // predictor state
   logic [LW_W-1:0]     width_cfg;
   int unsigned         words_seen;
   logic [PREFIX_W-1:0] prefix_ring   [WINDOW_DEPTH];
   logic [COST_W-1:0]   cost_ring     [WINDOW_DEPTH];
   bit                  feasible_ring [WINDOW_DEPTH];

   break_type        pending_breaks [$];
   directed_row_type directed_rows  [20];

   int error_count    = 0;
   int cycle_count    = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_left      = 0;

   min_raggedness_line_break u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_word_length (req_word_length),
      .req_last_word   (req_last_word),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_word_index  (rsp_word_index),
      .rsp_best_cost   (rsp_best_cost),
      .rsp_line_start  (rsp_line_start),
      .rsp_no_fit      (rsp_no_fit),
      .rsp_is_last     (rsp_is_last),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CLOCK_LIMIT) begin
         $display("min_raggedness_line_break regression: fail");
         $finish;
      end
   end

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      if (error_count < PRINT_LIMIT)
         $display("mismatch %s: got %0d, want %0d (t=%0t)", what, got, want, $realtime);
      error_count++;
   endtask

   // best split of the paragraph up to the incoming word, cubic slack penalty
   function automatic break_type predict_break(input logic [LEN_W-1:0] len, input logic last);
      break_type         r;
      int unsigned       j;
      int unsigned       span;
      int unsigned       first;
      int unsigned       slot_b;
      logic [PREFIX_W-1:0] pj;
      logic [PREFIX_W-1:0] total;
      longint            slack;
      longint unsigned   lc;
      longint unsigned   cand;
      longint unsigned   cost;
      bit                found;
      r = '0;
      r.is_last = last;
      if (words_seen >= MAX_WORDS) begin
         r.index  = IDX_W'(MAX_WORDS);
         r.cost   = COST_MAX;
         r.no_fit = 1'b1;
      end else begin
         j     = words_seen + 1;
         pj    = prefix_ring[(j - 1) % WINDOW_DEPTH] + PREFIX_W'(len);
         span  = (int'(width_cfg) + 1) / 2;
         if (span > SPAN_MAX)
            span = SPAN_MAX;
         first = (j + 1 > span + 1) ? j + 1 - span : 1;
         prefix_ring[j % WINDOW_DEPTH] = pj;
         found = 1'b0;
         cost  = COST_MAX;
         for (int unsigned i = first; i <= j && span > 0; i++) begin
            slot_b = (i - 1) % WINDOW_DEPTH;
            total  = pj - prefix_ring[slot_b];
            slack  = longint'(width_cfg) - longint'(j - i) - longint'(total);
            if (slack >= 0 && feasible_ring[slot_b]) begin
               lc   = last ? 0 : slack * slack * slack;
               cand = cost_ring[slot_b] + lc;
               if (cand > COST_MAX)
                  cand = COST_MAX;
               if (!found || cand < cost) begin
                  found   = 1'b1;
                  cost    = cand;
                  r.start = IDX_W'(i);
               end
            end
         end
         cost_ring[j % WINDOW_DEPTH]     = found ? COST_W'(cost) : COST_MAX;
         feasible_ring[j % WINDOW_DEPTH] = found;
         r.index  = IDX_W'(j);
         r.cost   = found ? COST_W'(cost) : COST_MAX;
         r.no_fit = !found;
         if (!last)
            words_seen = j;
      end
      if (last) begin
         words_seen       = 0;
         prefix_ring[0]   = '0;
         cost_ring[0]     = '0;
         feasible_ring[0] = 1'b1;
      end
      return r;
   endfunction

   // result side: random stalls, long hold-off on request, compare in order
   always @(posedge clock) begin
      break_type want;
      if (rsp_valid && rsp_ready) begin
         if (pending_breaks.size() == 0) begin
            report("result word with nothing pending, word_index", rsp_word_index, 0);
         end else begin
            want = pending_breaks.pop_front();
            if (rsp_word_index !== want.index)
               report("word_index", rsp_word_index, want.index);
            if (rsp_best_cost !== want.cost)
               report("best_cost", rsp_best_cost, want.cost);
            if (rsp_line_start !== want.start)
               report("line_start", rsp_line_start, want.start);
            if (rsp_no_fit !== want.no_fit)
               report("no_fit", rsp_no_fit, want.no_fit);
            if (rsp_is_last !== want.is_last)
               report("is_last", rsp_is_last, want.is_last);
         end
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic send_word(input logic [LEN_W-1:0] len, input logic last,
                            input logic known, input break_type typed);
      break_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_word_length <= len;
      req_last_word   <= last;
      do
         @(posedge clock);
      while (!req_ready);
      predicted = predict_break(len, last);
      pending_breaks.push_back(known ? typed : predicted);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_breaks.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input logic write, input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= {REG_LINE_WIDTH, 2'b00};
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do
         @(posedge clock);
      while (!csr_pready);
      rdata       = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_line_width(input logic [LW_W-1:0] width);
      logic [CSR_DATA_W-1:0] rdata;
      csr_access(1'b1, CSR_DATA_W'(width), rdata);
      width_cfg = width;
      csr_access(1'b0, '0, rdata);
      if (rdata !== CSR_DATA_W'(width))
         report("line_width readback", rdata, width);
   endtask

   // paragraphs of mostly fitting words, some long enough to wrap the rings,
   // with oversized and zero-length words mixed in
   task automatic run_paragraphs(input int n_words);
      int               para_left;
      int               pick;
      int               cap;
      logic [LEN_W-1:0] len;
      para_left = 0;
      cap = (width_cfg < 4) ? 1 : int'(width_cfg) / 4;
      for (int k = 0; k < n_words; k++) begin
         if (para_left == 0) begin
            pick = $urandom_range(99);
            para_left = (pick < 6) ? $urandom_range(257, 300) :
                        (pick < 10) ? 1 : $urandom_range(2, 40);
         end
         pick = $urandom_range(99);
         if (pick < 85)
            len = LEN_W'($urandom_range(1, cap));
         else if (pick < 95)
            len = LEN_W'($urandom_range(1, (width_cfg > 252) ? 255 : int'(width_cfg) + 2));
         else
            len = LEN_W'($urandom_range(0, 255));
         send_word(len, para_left == 1, 1'b0, '0);
         para_left--;
      end
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] rdata;
      width_cfg  = LINE_WIDTH_RESET;
      words_seen = 0;
      for (int k = 0; k < WINDOW_DEPTH; k++) begin
         prefix_ring[k]   = '0;
         cost_ring[k]     = '0;
         feasible_ring[k] = 1'b0;
      end
      feasible_ring[0] = 1'b1;

      directed_rows = '{
         '{8'd80,  1'b1, 1'b1, '{12'd1, 40'd0,      12'd1, 1'b0, 1'b1}},
         '{8'd255, 1'b1, 1'b1, '{12'd1, COST_MAX,   12'd0, 1'b1, 1'b1}},
         '{8'd0,   1'b1, 1'b1, '{12'd1, 40'd0,      12'd1, 1'b0, 1'b1}},
         '{8'd1,   1'b0, 1'b1, '{12'd1, 40'd493039, 12'd1, 1'b0, 1'b0}},
         '{8'd1,   1'b0, 1'b0, '0},
         '{8'd1,   1'b0, 1'b0, '0},
         '{8'd1,   1'b1, 1'b1, '{12'd4, 40'd0,      12'd1, 1'b0, 1'b1}},
         // a word wider than the line poisons every later start after it
         '{8'd255, 1'b0, 1'b1, '{12'd1, COST_MAX,   12'd0, 1'b1, 1'b0}},
         '{8'd1,   1'b0, 1'b1, '{12'd2, COST_MAX,   12'd0, 1'b1, 1'b0}},
         '{8'd1,   1'b1, 1'b1, '{12'd3, COST_MAX,   12'd0, 1'b1, 1'b1}},
         // equal words, expected results from the predictor
         '{8'd26,  1'b0, 1'b0, '0},
         '{8'd26,  1'b0, 1'b0, '0},
         '{8'd26,  1'b0, 1'b0, '0},
         '{8'd26,  1'b1, 1'b0, '0},
         '{8'd40,  1'b0, 1'b1, '{12'd1, 40'd64000,  12'd1, 1'b0, 1'b0}},
         '{8'd39,  1'b0, 1'b1, '{12'd2, 40'd0,      12'd1, 1'b0, 1'b0}},
         '{8'd79,  1'b1, 1'b1, '{12'd3, 40'd0,      12'd3, 1'b0, 1'b1}},
         '{8'd20,  1'b0, 1'b0, '0},
         '{8'd20,  1'b0, 1'b0, '0},
         '{8'd20,  1'b1, 1'b0, '0}
      };

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      csr_access(1'b0, '0, rdata);
      if (rdata !== CSR_DATA_W'(LINE_WIDTH_RESET))
         report("line_width after reset", rdata, LINE_WIDTH_RESET);
      foreach (directed_rows[k])
         send_word(directed_rows[k].len, directed_rows[k].last,
                   directed_rows[k].known, directed_rows[k].typed);
      wait_drained();

      set_line_width(8'd255);
      send_idle_pct = 55;
      run_paragraphs(150);
      wait_drained();

      set_line_width(8'd1);
      send_idle_pct  = 0;
      recv_stall_pct = 55;
      run_paragraphs(100);
      wait_drained();

      set_line_width(8'd0);
      send_idle_pct  = 21;
      recv_stall_pct = 21;
      run_paragraphs(40);
      wait_drained();

      set_line_width(8'd12);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_left      = HOLD_CYCLES;
      run_paragraphs(150);
      wait_drained();

      // narrow line, mostly one-character words
      set_line_width(8'd3);
      run_paragraphs(20);
      wait_drained();

      set_line_width(LW_W'($urandom_range(2, 254)));
      send_idle_pct  = 21;
      recv_stall_pct = 21;
      run_paragraphs(150);
      wait_drained();

      set_line_width(8'd80);
      send_idle_pct  = 55;
      recv_stall_pct = 0;
      run_paragraphs(150);
      wait_drained();

      if (error_count == 0)
         $display("min_raggedness_line_break regression: pass");
      else
         $display("min_raggedness_line_break regression: fail");
      $finish;
   end

endmodule
